FILE: rtl/srle_pkg.sv
// shared types and constants for the scanline run-length stream decoder
// no dependencies; imported by every rtl module of the block
package srle_pkg;

	localparam int LINE_WIDTH_W = 13;
	localparam logic [LINE_WIDTH_W-1:0] LINE_WIDTH_RESET = 13'd640;
	localparam int MAX_LINE_WIDTH_DEF = 4096;
	localparam int QUEUE_DEPTH = 2;

	localparam logic [7:0] TAG_NEW   = 8'd122;
	localparam logic [7:0] TAG_REUSE = 8'd51;

	localparam int OFFSET_BYTES = 8;

	typedef enum logic [1:0] {
		KIND_RUN = 2'd0,
		KIND_REF = 2'd1,
		KIND_BAD = 2'd2
	} kind_t;

	// one decoded result travelling from the parser to the output stage
	typedef struct packed {
		kind_t       kind;
		logic [7:0]  run_value;
		logic [7:0]  run_length;
		logic [63:0] reference_offset;
		logic        line_end;
	} rec_t;

	localparam int REC_W = $bits(rec_t);

endpackage

FILE: rtl/srle_queue.sv
// short flop-based queue of decoded results between parser and output stage
// depends on srle_pkg for the record type
module srle_queue import srle_pkg::*; #(
	parameter int DEPTH = QUEUE_DEPTH
) (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  rec_t push_rec,
	output logic full,
	input  logic pop,
	output logic nonempty,
	output rec_t head_rec
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(DEPTH);

	rec_t             slot_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	logic do_push;
	logic do_pop;

	assign full     = (count_q == DEPTH_CNT);
	assign nonempty = (count_q != '0);
	assign head_rec = slot_q[rd_ptr_q];
	assign do_push  = push && !full;
	assign do_pop   = pop && nonempty;

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= push_rec;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({do_push, do_pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

FILE: rtl/srle_front.sv
// byte parser: holds the line width register, classifies stream bytes and
// builds result records; depends on srle_pkg
module srle_front import srle_pkg::*; #(
	parameter int MAX_LINE_WIDTH = MAX_LINE_WIDTH_DEF
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    cfg_valid,
	output logic                    cfg_ready,
	input  logic [LINE_WIDTH_W-1:0] cfg_data,
	input  logic                    byte_valid,
	output logic                    byte_ready,
	input  logic [7:0]              byte_data,
	output logic                    push,
	output rec_t                    push_rec,
	input  logic                    queue_full
);

	// pixel counter only needs to reach the clamped width
	localparam int PW = (MAX_LINE_WIDTH > 8191) ? LINE_WIDTH_W : $clog2(MAX_LINE_WIDTH + 1);
	localparam int CW = (PW > 8) ? PW : 8;
	localparam logic [PW-1:0] MAX_W = PW'(MAX_LINE_WIDTH);
	localparam logic [2:0] LAST_OFFSET_BYTE = 3'(OFFSET_BYTES - 1);

	typedef enum logic [3:0] {
		PH_TAG    = 4'b0001,
		PH_COUNT  = 4'b0010,
		PH_VALUE  = 4'b0100,
		PH_OFFSET = 4'b1000
	} phase_t;

	logic [LINE_WIDTH_W-1:0] line_width_q;
	phase_t                  phase_q, phase_d;
	logic [7:0]              count_q, count_d;
	logic [PW-1:0]           pixels_q, pixels_d;
	logic [63:0]             offset_q, offset_d;
	logic [2:0]              obytes_q, obytes_d;

	logic          accept;
	logic [PW-1:0] eff_w;
	logic [PW-1:0] remaining;
	logic [CW-1:0] count_ext;
	logic [CW-1:0] remain_ext;
	logic [CW-1:0] run_ext;
	logic [63:0]   offset_shifted;

	assign cfg_ready  = 1'b1;
	assign byte_ready = !queue_full;
	assign accept     = byte_valid && byte_ready;

	assign eff_w = (32'(line_width_q) > 32'(MAX_LINE_WIDTH)) ? MAX_W : line_width_q[PW-1:0];
	assign remaining  = (eff_w > pixels_q) ? (eff_w - pixels_q) : '0;
	assign count_ext  = CW'(count_q);
	assign remain_ext = CW'(remaining);
	assign run_ext    = (count_ext < remain_ext) ? count_ext : remain_ext;
	// little-endian offset: each byte enters at the top and shifts down
	assign offset_shifted = {byte_data, offset_q[63:8]};

	always_comb begin
		phase_d  = phase_q;
		count_d  = count_q;
		pixels_d = pixels_q;
		offset_d = offset_q;
		obytes_d = obytes_q;
		push     = 1'b0;
		push_rec = '{kind: KIND_RUN, run_value: 8'd0, run_length: 8'd0,
			reference_offset: 64'd0, line_end: 1'b0};
		case (phase_q)
			PH_TAG: begin
				if (byte_data == TAG_NEW) begin
					pixels_d = '0;
					if (eff_w == '0) begin
						push              = 1'b1;
						push_rec.line_end = 1'b1;
					end else begin
						phase_d = PH_COUNT;
					end
				end else if (byte_data == TAG_REUSE) begin
					offset_d = '0;
					obytes_d = '0;
					phase_d  = PH_OFFSET;
				end else begin
					push               = 1'b1;
					push_rec.kind      = KIND_BAD;
					push_rec.run_value = byte_data;
				end
			end
			PH_COUNT: begin
				count_d = byte_data;
				phase_d = PH_VALUE;
			end
			PH_VALUE: begin
				if (remaining == '0) begin
					phase_d            = PH_TAG;
					push               = 1'b1;
					push_rec.run_value = byte_data;
					push_rec.line_end  = 1'b1;
				end else if (count_q == 8'd0) begin
					phase_d = PH_COUNT;
				end else begin
					pixels_d            = pixels_q + PW'(run_ext);
					push                = 1'b1;
					push_rec.run_value  = byte_data;
					push_rec.run_length = run_ext[7:0];
					if (run_ext == remain_ext) begin
						phase_d           = PH_TAG;
						push_rec.line_end = 1'b1;
					end else begin
						phase_d = PH_COUNT;
					end
				end
			end
			PH_OFFSET: begin
				if (obytes_q == LAST_OFFSET_BYTE) begin
					push                      = 1'b1;
					push_rec.kind             = KIND_REF;
					push_rec.reference_offset = offset_shifted;
					push_rec.line_end         = 1'b1;
					offset_d                  = '0;
					obytes_d                  = '0;
					phase_d                   = PH_TAG;
				end else begin
					offset_d = offset_shifted;
					obytes_d = obytes_q + 3'd1;
				end
			end
			default: begin
				phase_d = PH_TAG;
			end
		endcase
		if (!accept) begin
			push = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_width_q <= LINE_WIDTH_RESET;
			phase_q      <= PH_TAG;
			count_q      <= '0;
			pixels_q     <= '0;
			offset_q     <= '0;
			obytes_q     <= '0;
		end else begin
			if (cfg_valid) begin
				line_width_q <= cfg_data;
			end
			if (accept) begin
				phase_q  <= phase_d;
				count_q  <= count_d;
				pixels_q <= pixels_d;
				offset_q <= offset_d;
				obytes_q <= obytes_d;
			end
		end
	end

endmodule

FILE: rtl/srle_back.sv
// output stage: takes records off the queue into a registered master beat
// depends on srle_pkg for the record type
module srle_back import srle_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        rec_valid,
	input  rec_t        rec,
	output logic        pop,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [79:0] m_axis_tdata,
	output logic [1:0]  m_axis_tuser,
	output logic        m_axis_tlast
);

	logic        valid_q;
	logic [79:0] data_q;
	logic [1:0]  user_q;
	logic        last_q;

	assign pop = rec_valid && (!valid_q || m_axis_tready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (!valid_q || m_axis_tready) begin
			valid_q <= rec_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			data_q <= {rec.reference_offset, rec.run_length, rec.run_value};
			user_q <= rec.kind;
			last_q <= rec.line_end;
		end
	end

	assign m_axis_tvalid = valid_q;
	assign m_axis_tdata  = data_q;
	assign m_axis_tuser  = user_q;
	assign m_axis_tlast  = last_q;

endmodule

FILE: rtl/scanline_rle_stream_decoder.sv
// top level of the scanline run-length stream decoder
// joins srle_front, srle_queue and srle_back; depends on srle_pkg
//
// channel   dir  beat content
// --------  ---  ------------------------------------------------------------
// s_axis    in   one compressed stream byte (tag, count, value or offset byte)
// cfg       in   line_width, pixels per scanline (13 bits)
// m_axis    out  one decoded result: run, reuse reference or bad tag
//
// one input byte per cycle while the queue is not full; the parser updates its state in the
// cycle the byte is taken, so bytes may follow back to back
// a result is written into the two-entry queue by the byte that causes it and
// passes from the queue head into the output register
// the input stalls only when the queue is full, i.e. when m_axis has been held
// off long enough to back up both queue entries behind the output register
// reset brings line_width to 640 and the parser back to awaiting a tag byte
module scanline_rle_stream_decoder import srle_pkg::*; #(
	parameter int MAX_LINE_WIDTH = MAX_LINE_WIDTH_DEF
) (
	input  logic                    clk,
	input  logic                    arst_n,
	// slave stream of compressed bytes
	input  logic                    s_axis_tvalid,
	output logic                    s_axis_tready,
	input  logic [7:0]              s_axis_tdata,  // [7:0] in_byte
	// line width register write
	input  logic                    cfg_valid,
	output logic                    cfg_ready,
	input  logic [LINE_WIDTH_W-1:0] cfg_data,      // [12:0] line_width
	// master stream of results
	output logic                    m_axis_tvalid,
	input  logic                    m_axis_tready,
	output logic [79:0]             m_axis_tdata,  // [7:0] run_value, [15:8] run_length,
	                                               // [79:16] reference_offset
	output logic [1:0]              m_axis_tuser,  // [1:0] kind
	output logic                    m_axis_tlast   // line_end
);

	// parser to queue
	logic push;
	rec_t push_rec;
	logic queue_full;

	// queue to output stage
	logic pop;
	logic head_valid;
	rec_t head_rec;

	// front: owns all parse state and clips runs to the width still missing
	srle_front #(
		.MAX_LINE_WIDTH(MAX_LINE_WIDTH)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data),
		.byte_valid(s_axis_tvalid),
		.byte_ready(s_axis_tready),
		.byte_data (s_axis_tdata),
		.push      (push),
		.push_rec  (push_rec),
		.queue_full(queue_full)
	);

	// decouples parser from output back-pressure
	srle_queue #(
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.push_rec(push_rec),
		.full    (queue_full),
		.pop     (pop),
		.nonempty(head_valid),
		.head_rec(head_rec)
	);

	// back: registered master beat, refilled in the cycle it is taken
	srle_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.rec_valid    (head_valid),
		.rec          (head_rec),
		.pop          (pop),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tuser (m_axis_tuser),
		.m_axis_tlast (m_axis_tlast)
	);

endmodule

FILE: sim/tb_top.sv
// self-checking testbench for scanline_rle_stream_decoder: directed and random byte streams
// carries its own decoder model and a results checker; depends on srle_pkg and the rtl
`timescale 1ns / 100ps

module tb_top;
	import srle_pkg::*;

	// parser phases of the local decoder model
	typedef enum int {
		AWAIT_TAG,
		AWAIT_COUNT,
		AWAIT_VALUE,
		AWAIT_OFFSET
	} parse_phase_t;

	localparam int SETTLE_CYCLES = 6;       // margin kept after the last predicted result
	localparam int DRAIN_LIMIT   = 20000;   // cycles allowed for the final drain
	localparam int OFFSET_LAST   = OFFSET_BYTES - 1;

	logic                    clk;
	logic                    arst_n = 1'b0;
	logic                    s_axis_tvalid = 1'b0;
	logic                    s_axis_tready;
	logic [7:0]              s_axis_tdata = '0;  // [7:0] in_byte
	logic                    cfg_valid = 1'b0;
	logic                    cfg_ready;
	logic [LINE_WIDTH_W-1:0] cfg_data = '0;      // [12:0] line_width
	logic                    m_axis_tvalid;
	logic                    m_axis_tready = 1'b0;
	logic [79:0]             m_axis_tdata;       // [7:0] run_value, [15:8] run_length,
	                                             // [79:16] reference_offset
	logic [1:0]              m_axis_tuser;       // [1:0] kind
	logic                    m_axis_tlast;       // line_end

	// decoder model state, updated as each byte beat is accepted
	logic [LINE_WIDTH_W-1:0] line_width_q;
	parse_phase_t            cur_phase;
	int unsigned             held_count;
	int unsigned             pixels_filled;
	logic [63:0]             offset_acc;
	int unsigned             offset_count;

	rec_t decoded_results[$];   // predicted result beats, oldest first
	rec_t oldest_rec;
	int   fails = 0;
	int   bytes_sent = 0;
	bit   tx_gap_en = 1'b1;
	bit   rx_stall_en = 1'b1;
	int   rx_hold = 0;

	scanline_rle_stream_decoder #(
		.MAX_LINE_WIDTH(MAX_LINE_WIDTH_DEF)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.m_axis_tuser(m_axis_tuser),
		.m_axis_tlast(m_axis_tlast)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// generous fixed limit on the whole run
	initial begin
		#4_000_000;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	// idle length: mostly short, now and then long
	function automatic int idle_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 65)
			return $urandom_range(1, 2);
		if (r < 92)
			return $urandom_range(3, 6);
		return $urandom_range(10, 40);
	endfunction

	// count byte: zero now and then, short runs, full runs, anything
	function automatic logic [7:0] pick_count();
		int r;
		r = $urandom_range(0, 99);
		if (r < 6)
			return 8'd0;
		if (r < 26)
			return 8'($urandom_range(1, 8));
		if (r < 36)
			return 8'd255;
		return 8'($urandom_range(0, 255));
	endfunction

	// model of the parser: consumes one byte, queues the result it causes, if any
	task automatic decode_byte(input logic [7:0] b);
		rec_t        r;
		bit          emit;
		int unsigned w;
		int unsigned remaining;
		int unsigned run;
		emit = 1'b0;
		r.kind = KIND_RUN;
		r.run_value = '0;
		r.run_length = '0;
		r.reference_offset = '0;
		r.line_end = 1'b0;
		// widths above the maximum behave as the maximum
		w = (line_width_q > MAX_LINE_WIDTH_DEF) ? MAX_LINE_WIDTH_DEF : line_width_q;
		case (cur_phase)
			AWAIT_TAG: begin
				if (b == TAG_NEW) begin
					pixels_filled = 0;
					if (w == 0) begin
						// zero width: an empty line at once, no pairs read
						emit = 1'b1;
						r.line_end = 1'b1;
					end else begin
						cur_phase = AWAIT_COUNT;
					end
				end else if (b == TAG_REUSE) begin
					offset_acc = '0;
					offset_count = 0;
					cur_phase = AWAIT_OFFSET;
				end else begin
					// unknown tag: reported and dropped, still waiting for a tag
					emit = 1'b1;
					r.kind = KIND_BAD;
					r.run_value = b;
				end
			end
			AWAIT_COUNT: begin
				held_count = b;
				cur_phase = AWAIT_VALUE;
			end
			AWAIT_VALUE: begin
				remaining = (w > pixels_filled) ? w - pixels_filled : 0;
				if (remaining == 0) begin
					// line already full after a width change: empty closing run
					emit = 1'b1;
					r.run_value = b;
					r.line_end = 1'b1;
					cur_phase = AWAIT_TAG;
				end else if (held_count == 0) begin
					cur_phase = AWAIT_COUNT;
				end else begin
					run = (held_count < remaining) ? held_count : remaining;
					pixels_filled += run;
					emit = 1'b1;
					r.run_value = b;
					r.run_length = 8'(run);
					r.line_end = (run == remaining);
					cur_phase = (run == remaining) ? AWAIT_TAG : AWAIT_COUNT;
				end
			end
			AWAIT_OFFSET: begin
				offset_acc = offset_acc | (64'(b) << (offset_count * 8));
				if (offset_count == OFFSET_LAST) begin
					emit = 1'b1;
					r.kind = KIND_REF;
					r.reference_offset = offset_acc;
					r.line_end = 1'b1;
					offset_acc = '0;
					offset_count = 0;
					cur_phase = AWAIT_TAG;
				end else begin
					offset_count++;
				end
			end
		endcase
		if (emit)
			decoded_results.push_back(r);
	endtask

	// one byte beat; tvalid stays high into the next call unless a gap is taken
	task automatic send_byte(input logic [7:0] b);
		int gap;
		gap = (tx_gap_en && $urandom_range(0, 3) == 0) ? idle_len() : 0;
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= b;
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		decode_byte(b);
		bytes_sent++;
	endtask

	// hold the input until every predicted result has been seen
	task automatic wait_results_drained();
		s_axis_tvalid <= 1'b0;
		while (decoded_results.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// register write, only ever issued with the decoder drained
	task automatic write_line_width(input logic [LINE_WIDTH_W-1:0] w);
		wait_results_drained();
		cfg_valid <= 1'b1;
		cfg_data <= w;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		line_width_q = w;
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	// well-formed line: new-line tag, then pairs until the model says it is full
	task automatic send_line();
		send_byte(TAG_NEW);
		while (cur_phase != AWAIT_TAG) begin
			if (cur_phase == AWAIT_COUNT)
				send_byte(pick_count());
			else
				send_byte(8'($urandom_range(0, 255)));
		end
	endtask

	task automatic send_reuse(input int n_bytes);
		send_byte(TAG_REUSE);
		repeat (n_bytes) begin
			case ($urandom_range(0, 5))
				0:       send_byte(8'h00);
				1:       send_byte(8'hff);
				default: send_byte(8'($urandom_range(0, 255)));
			endcase
		end
	endtask

	// ------------------------------------------------------------------
	// directed tests
	// ------------------------------------------------------------------

	// reset width of 640: zero count, two full runs, then an overshoot clipped to 130
	task automatic test_runs_default_width();
		send_byte(TAG_NEW);
		send_byte(8'd0);
		send_byte(8'h11);
		send_byte(8'd255);
		send_byte(8'h00);
		send_byte(8'd255);
		send_byte(8'hff);
		send_byte(8'd200);
		send_byte(8'h80);
	endtask

	// reuse reference with a little-endian offset of distinct bytes
	task automatic test_reuse_reference();
		logic [63:0] offs;
		offs = 64'hefcd_ab89_6745_2301;
		send_byte(TAG_REUSE);
		for (int i = 0; i < OFFSET_BYTES; i++)
			send_byte(offs[i*8 +: 8]);
	endtask

	// bad tags at the byte extremes and next to both good tags
	task automatic test_bad_tags();
		send_byte(8'h00);
		send_byte(8'hff);
		send_byte(TAG_NEW - 8'd1);
		send_byte(TAG_REUSE + 8'd1);
	endtask

	// width of one pixel, then zero width where the tag alone closes the line
	task automatic test_narrow_widths();
		write_line_width(13'd1);
		send_byte(TAG_NEW);
		send_byte(8'd1);
		send_byte(8'h7e);
		write_line_width(13'd0);
		send_byte(TAG_NEW);
	endtask

	// width lowered below the pixels already decoded while a line is open
	task automatic test_width_lowered_midline();
		write_line_width(13'd100);
		send_byte(TAG_NEW);
		send_byte(8'd60);
		send_byte(8'haa);
		write_line_width(13'd40);
		send_byte(8'd5);
		send_byte(8'h55);
	endtask

	// ------------------------------------------------------------------
	// random traffic, one width setting per phase
	// ------------------------------------------------------------------
	task automatic random_phase(input logic [LINE_WIDTH_W-1:0] w, input int budget);
		int start;
		int r;
		write_line_width(w);
		start = bytes_sent;
		while (bytes_sent - start < budget) begin
			// switch idling on and off so that quiet stretches also occur
			if ($urandom_range(0, 9) == 0)
				tx_gap_en = !tx_gap_en;
			if ($urandom_range(0, 9) == 0)
				rx_stall_en = !rx_stall_en;
			r = $urandom_range(0, 99);
			if (r < 55)
				send_line();
			else if (r < 75)
				send_reuse(OFFSET_BYTES);
			else if (r < 85)
				send_byte(8'($urandom_range(0, 255)));
			else if (r < 93) begin
				// line cut short, the following bytes land mid-line
				send_byte(TAG_NEW);
				repeat ($urandom_range(0, 3))
					send_byte(8'($urandom_range(0, 255)));
			end else
				send_reuse($urandom_range(0, OFFSET_LAST));
			if ($urandom_range(0, 29) == 0)
				wait_results_drained();
		end
		// leave a line open now and then so the next width applies mid-line
		if ($urandom_range(0, 1) == 0) begin
			send_byte(TAG_NEW);
			send_byte(8'($urandom_range(1, 20)));
			send_byte(8'($urandom_range(0, 255)));
		end
	endtask

	task automatic test_random_traffic();
		random_phase(13'd1, 180);
		random_phase(13'($urandom_range(2, 64)), 200);
		random_phase(13'd640, 180);
		random_phase(13'd0, 120);
		random_phase(13'(MAX_LINE_WIDTH_DEF), 140);
		random_phase(13'($urandom_range(1, 300)), 200);
		random_phase(13'h1fff, 120);
		random_phase(13'($urandom_range(MAX_LINE_WIDTH_DEF + 1, 8190)), 100);
		random_phase(13'($urandom_range(1, 40)), 180);
	endtask

	// result sink: random back-pressure on the master stream
	always @(posedge clk) begin
		if (rx_hold > 0)
			rx_hold = rx_hold - 1;
		else if (rx_stall_en && $urandom_range(0, 4) == 0) begin
			m_axis_tready <= 1'b0;
			rx_hold = idle_len() - 1;
		end else begin
			m_axis_tready <= 1'b1;
		end
	end

	// result checker: every result beat against the oldest prediction
	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (decoded_results.size() == 0) begin
				$error("result beat with none expected: tuser %0d tdata %h tlast %b",
					m_axis_tuser, m_axis_tdata, m_axis_tlast);
				fails++;
			end else begin
				oldest_rec = decoded_results.pop_front();
				if (m_axis_tuser !== oldest_rec.kind) begin
					$error("kind: expected %0d, got %0d", oldest_rec.kind, m_axis_tuser);
					fails++;
				end
				if (m_axis_tdata[7:0] !== oldest_rec.run_value) begin
					$error("run_value: expected %0d, got %0d",
						oldest_rec.run_value, m_axis_tdata[7:0]);
					fails++;
				end
				if (m_axis_tdata[15:8] !== oldest_rec.run_length) begin
					$error("run_length: expected %0d, got %0d",
						oldest_rec.run_length, m_axis_tdata[15:8]);
					fails++;
				end
				if (m_axis_tdata[79:16] !== oldest_rec.reference_offset) begin
					$error("reference_offset: expected %h, got %h",
						oldest_rec.reference_offset, m_axis_tdata[79:16]);
					fails++;
				end
				if (m_axis_tlast !== oldest_rec.line_end) begin
					$error("line_end: expected %b, got %b",
						oldest_rec.line_end, m_axis_tlast);
					fails++;
				end
			end
		end
	end

	initial begin
		int waited;
		// model starts from the reset state of the block
		line_width_q = LINE_WIDTH_RESET;
		cur_phase = AWAIT_TAG;
		held_count = 0;
		pixels_filled = 0;
		offset_acc = '0;
		offset_count = 0;

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_runs_default_width();
		test_reuse_reference();
		test_bad_tags();
		test_narrow_widths();
		test_width_lowered_midline();
		test_random_traffic();

		// final drain, bounded
		s_axis_tvalid <= 1'b0;
		waited = 0;
		while (decoded_results.size() != 0 && waited < DRAIN_LIMIT) begin
			@(posedge clk);
			waited++;
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (decoded_results.size() != 0) begin
			$error("%0d predicted result beats never arrived", decoded_results.size());
			fails++;
		end

		if (fails == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
